@@ design/ctr_pkg.sv @@
`default_nettype none

package ctr_pkg;

    // Item formats
    localparam int ANGLE_FRAC_BITS  = 24;
    localparam int RESULT_FRAC_BITS = 30;
    localparam int ANGLE_W          = 32;
    localparam int RESULT_W         = 32;

    // Range reduction works with 40 fraction bits
    localparam int FIX_FRAC = 40;
    localparam int PI_W     = 42;
    localparam logic [PI_W-1:0] PI_Q40      = 42'h3243F6A8886;
    localparam logic [PI_W-1:0] HALF_PI_Q40 = 42'h1921FB54443;

    localparam int MAG_W    = ANGLE_W;
    localparam int ALIGN_SH = FIX_FRAC - ANGLE_FRAC_BITS;
    localparam int M40_W    = MAG_W + ALIGN_SH;

    // Estimate of |x|/pi: (mag * TURN_RECIP) >> RECIP_SH, low by at most one
    localparam int          RECIP_SH   = 32;
    localparam logic [63:0] TURN_RECIP = (64'd1 << (RECIP_SH + ALIGN_SH)) / 64'(PI_Q40);
    localparam int          RECIP_W    = $clog2(TURN_RECIP + 64'd1);
    localparam logic [63:0] Q_MAX      = (64'd1 << (MAG_W - 1 + ALIGN_SH)) / 64'(PI_Q40);
    localparam int          Q_W        = $clog2(Q_MAX + 64'd2);
    localparam int          QPROD_W    = MAG_W + RECIP_W;
    localparam int          QP_W       = Q_W + PI_W;
    localparam int          DIFF_W     = (M40_W > QP_W) ? M40_W : QP_W;
    localparam int          REM_W      = PI_W + 1;

    // Folded magnitude, 40 then 31 fraction bits
    localparam int FRAC_POLY = 31;
    localparam int A40_W     = PI_W - 1;
    localparam int RND_SH    = FIX_FRAC - FRAC_POLY;
    localparam int A31_W     = A40_W - RND_SH;

    // Polynomial
    localparam int SQ_W  = 2 * A31_W;
    localparam int X2_W  = 33;
    localparam int T_W   = 32;
    localparam int TP_W  = T_W + X2_W;
    localparam int V_W   = 32;
    localparam int ACC_W = 35;

    // Terms after x^2/2: divisor d = odd * 2^pow, odd part divided by reciprocal
    localparam int N_TERMS        = 3;
    localparam int TERM_POW_MAX   = 3;
    localparam int TERM_LOG_MAX   = 4;
    localparam int RECIP_BASE     = 32;
    localparam int TERM_RECIP_W   = 33;
    localparam int PS_W           = FRAC_POLY + TERM_POW_MAX + V_W;
    localparam int MR_W           = RECIP_BASE + TERM_LOG_MAX + T_W;
    localparam int TERM_DIV [N_TERMS] = '{12, 30, 56};
    localparam int TERM_POW [N_TERMS] = '{2, 1, 3};
    localparam int TERM_LOG [N_TERMS] = '{2, 4, 3};
    localparam logic [TERM_RECIP_W-1:0] TERM_RECIP [N_TERMS] = '{
        TERM_RECIP_W'(((64'd1 << 34) + 64'd2) / 64'd3),
        TERM_RECIP_W'(((64'd1 << 36) + 64'd14) / 64'd15),
        TERM_RECIP_W'(((64'd1 << 35) + 64'd6) / 64'd7)
    };
    // Subtract x^2/2 and x^6/720, add x^4/24; x^8/8! is added at the end
    localparam logic TERM_NEG [N_TERMS] = '{1'b1, 1'b0, 1'b1};

    localparam logic signed [ACC_W-1:0] ONE_Q31  = ACC_W'(64'd1 << FRAC_POLY);
    localparam int                      RES_SH   = FRAC_POLY - RESULT_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] RES_HALF =
        (RES_SH > 0) ? ACC_W'(64'd1 << (RES_SH - 1)) : '0;
    localparam logic signed [ACC_W-1:0] RES_LIM  = ACC_W'(64'd1 << RESULT_FRAC_BITS);

    // Pipeline depths
    localparam int N_RED  = 6;
    localparam int N_POLY = 3 + 3 * N_TERMS + 3;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic             flip;
        logic [A31_W-1:0] mag;
    } ctr_red_t;

    typedef struct packed {
        logic                       vld;
        logic                       last;
        logic signed [RESULT_W-1:0] cosine;
    } ctr_res_t;

endpackage

`default_nettype wire

@@ design/ctr_reduce.sv @@
`default_nettype none

module ctr_reduce
    import ctr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_vld,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic                      last_in,
    output ctr_red_t                  red
);

    logic [N_RED-1:0]   vld_reg;
    logic [N_RED-1:0]   last_reg;

    logic [MAG_W-1:0]   raw;
    logic [MAG_W-1:0]   mag_next;
    logic [MAG_W-1:0]   mag1_reg;
    logic [MAG_W-1:0]   mag2_reg;
    logic [MAG_W-1:0]   mag3_reg;
    logic [QPROD_W-1:0] qprod_next;
    logic [QPROD_W-1:0] qprod_reg;
    logic [Q_W-1:0]     qest;
    logic [QP_W-1:0]    qp_next;
    logic [QP_W-1:0]    qp_reg;
    logic               q0_reg;
    logic [DIFF_W-1:0]  diff;
    logic [REM_W-1:0]   rem0;
    logic [REM_W-1:0]   rem1;
    logic               ge_pi;
    logic [PI_W-1:0]    rem_next;
    logic [PI_W-1:0]    rem_reg;
    logic               odd_next;
    logic               odd_reg;
    logic [PI_W-1:0]    near;
    logic               above_half;
    logic               below_half;
    logic               use_near;
    logic               flip_next;
    logic [A40_W-1:0]   a40_next;
    logic [A40_W-1:0]   a40_reg;
    logic               flip5_reg;
    logic [A40_W-1:0]   a_sum;
    logic [A31_W-1:0]   a31_next;
    logic [A31_W-1:0]   a31_reg;
    logic               flip6_reg;

    always_comb
    begin
        // magnitude; the most negative angle gives 2^31 exactly
        raw      = angle;
        mag_next = raw[MAG_W-1] ? (~raw) + MAG_W'(1) : raw;

        qprod_next = QPROD_W'(mag1_reg) * QPROD_W'(TURN_RECIP[RECIP_W-1:0]);

        qest    = qprod_reg[RECIP_SH +: Q_W];
        qp_next = QP_W'(qest) * QP_W'(PI_Q40);

        // remainder by pi, one correction step for the low estimate
        diff     = DIFF_W'({mag3_reg, {ALIGN_SH{1'b0}}}) - DIFF_W'(qp_reg);
        rem0     = diff[REM_W-1:0];
        rem1     = rem0 - REM_W'(PI_Q40);
        ge_pi    = rem0 >= REM_W'(PI_Q40);
        rem_next = ge_pi ? rem1[PI_W-1:0] : rem0[PI_W-1:0];
        odd_next = q0_reg ^ ge_pi;

        // odd quotient: residue is rem - pi; fold beyond pi/2 in either case
        near       = PI_Q40 - rem_reg;
        above_half = rem_reg > HALF_PI_Q40;
        below_half = rem_reg < HALF_PI_Q40;
        flip_next  = odd_reg ? below_half : above_half;
        use_near   = odd_reg ? !below_half : above_half;
        a40_next   = use_near ? near[A40_W-1:0] : rem_reg[A40_W-1:0];

        a_sum    = a40_reg + A40_W'(64'd1 << (RND_SH - 1));
        a31_next = a_sum[RND_SH +: A31_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N_RED-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg  <= {last_reg[N_RED-2:0], last_in};
            mag1_reg  <= mag_next;
            mag2_reg  <= mag1_reg;
            qprod_reg <= qprod_next;
            mag3_reg  <= mag2_reg;
            qp_reg    <= qp_next;
            q0_reg    <= qest[0];
            rem_reg   <= rem_next;
            odd_reg   <= odd_next;
            a40_reg   <= a40_next;
            flip5_reg <= flip_next;
            a31_reg   <= a31_next;
            flip6_reg <= flip5_reg;
        end
    end

    assign red.vld  = vld_reg[N_RED-1];
    assign red.last = last_reg[N_RED-1];
    assign red.flip = flip6_reg;
    assign red.mag  = a31_reg;

endmodule

`default_nettype wire

@@ design/ctr_poly.sv @@
`default_nettype none

module ctr_poly
    import ctr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  ctr_red_t red,
    output ctr_res_t res
);

    logic [N_POLY-1:0] vld_reg;
    logic [N_POLY-1:0] last_reg;
    logic [N_POLY-2:0] flip_reg;

    logic [SQ_W-1:0]   sq_next;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W:0]     sq_sum;
    logic [X2_W-1:0]   x2_next;
    logic [X2_W-1:0]   x2_reg;
    logic [X2_W-1:0]   x2p_reg;
    logic [X2_W:0]     t1_sum;
    logic [T_W-1:0]    t1_next;
    logic [T_W-1:0]    t1_reg;

    logic [T_W-1:0]          t_src   [N_TERMS+1];
    logic [X2_W-1:0]         x_src   [N_TERMS];
    logic signed [ACC_W-1:0] acc_src [N_TERMS+1];

    logic signed [ACC_W-1:0] accf_next;
    logic signed [ACC_W-1:0] accf_reg;
    logic signed [ACC_W-1:0] rsum;
    logic signed [ACC_W-1:0] rnd_next;
    logic signed [ACC_W-1:0] rnd_reg;
    logic signed [ACC_W-1:0] sgn;
    logic signed [ACC_W-1:0] sat;
    logic signed [RESULT_W-1:0] cos_reg;

    always_comb
    begin
        sq_next = SQ_W'(red.mag) * SQ_W'(red.mag);
        sq_sum  = (SQ_W + 1)'(sq_reg) + ((SQ_W + 1)'(1) << (FRAC_POLY - 1));
        x2_next = sq_sum[FRAC_POLY +: X2_W];
        // x^2/2 with round half up reduces to (x2 + 1) / 2
        t1_sum  = (X2_W + 1)'(x2_reg) + (X2_W + 1)'(1);
        t1_next = t1_sum[1 +: T_W];
    end

    assign t_src[0]   = t1_reg;
    assign x_src[0]   = x2p_reg;
    assign acc_src[0] = ONE_Q31;

    for (genvar j = 0; j < N_TERMS; j++)
    begin : g_term
        localparam logic [PS_W-1:0] T_HALF = PS_W'(TERM_DIV[j]) << (FRAC_POLY - 1);
        localparam int              T_SH   = FRAC_POLY + TERM_POW[j];
        localparam int              T_LSB  = RECIP_BASE + TERM_LOG[j];

        logic [TP_W-1:0]         prod_next;
        logic [TP_W-1:0]         prod_reg;
        logic signed [ACC_W-1:0] t_ext;
        logic signed [ACC_W-1:0] acc_next;
        logic signed [ACC_W-1:0] acca_reg;
        logic signed [ACC_W-1:0] accb_reg;
        logic signed [ACC_W-1:0] accc_reg;
        logic [PS_W-1:0]         psum;
        logic [V_W-1:0]          v_next;
        logic [V_W-1:0]          v_reg;
        logic [MR_W-1:0]         mr_next;
        logic [MR_W-1:0]         mr_reg;

        always_comb
        begin
            prod_next = TP_W'(t_src[j]) * TP_W'(x_src[j]);
            t_ext     = $signed({{(ACC_W - T_W){1'b0}}, t_src[j]});
            acc_next  = TERM_NEG[j] ? acc_src[j] - t_ext : acc_src[j] + t_ext;
            // scale by the power-of-two part of the divisor, then the odd part
            psum      = PS_W'(prod_reg) + T_HALF;
            v_next    = psum[T_SH +: V_W];
            mr_next   = MR_W'(v_reg) * MR_W'(TERM_RECIP[j]);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                prod_reg <= prod_next;
                acca_reg <= acc_next;
                v_reg    <= v_next;
                accb_reg <= acca_reg;
                mr_reg   <= mr_next;
                accc_reg <= accb_reg;
            end
        end

        assign t_src[j+1]   = mr_reg[T_LSB +: T_W];
        assign acc_src[j+1] = accc_reg;

        if (j < N_TERMS - 1)
        begin : g_fwd
            logic [X2_W-1:0] xa_reg;
            logic [X2_W-1:0] xb_reg;
            logic [X2_W-1:0] xc_reg;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    xa_reg <= x_src[j];
                    xb_reg <= xa_reg;
                    xc_reg <= xb_reg;
                end
            end

            assign x_src[j+1] = xc_reg;
        end
    end

    always_comb
    begin
        accf_next = acc_src[N_TERMS]
                  + $signed({{(ACC_W - T_W){1'b0}}, t_src[N_TERMS]});
        // round half toward plus infinity
        rsum      = accf_reg + RES_HALF;
        rnd_next  = rsum >>> RES_SH;
        sgn       = flip_reg[N_POLY-2] ? -rnd_reg : rnd_reg;
        if (sgn > RES_LIM)
        begin
            sat = RES_LIM;
        end
        else if (sgn < -RES_LIM)
        begin
            sat = -RES_LIM;
        end
        else
        begin
            sat = sgn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N_POLY-2:0], red.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= {last_reg[N_POLY-2:0], red.last};
            flip_reg <= {flip_reg[N_POLY-3:0], red.flip};
            sq_reg   <= sq_next;
            x2_reg   <= x2_next;
            x2p_reg  <= x2_reg;
            t1_reg   <= t1_next;
            accf_reg <= accf_next;
            rnd_reg  <= rnd_next;
            cos_reg  <= sat[RESULT_W-1:0];
        end
    end

    assign res.vld    = vld_reg[N_POLY-1];
    assign res.last   = last_reg[N_POLY-1];
    assign res.cosine = cos_reg;

endmodule

`default_nettype wire

@@ design/ctr_skid.sv @@
`default_nettype none

module ctr_skid
    import ctr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctr_res_t                   res,
    input  logic                       stall,
    output logic                       adv,
    output logic                       valid,
    output logic signed [RESULT_W-1:0] cosine,
    output logic                       last
);

    logic                       out_v_reg;
    logic                       out_v_next;
    logic signed [RESULT_W-1:0] out_cos_reg;
    logic                       out_last_reg;
    logic                       sk_v_reg;
    logic                       sk_v_next;
    logic signed [RESULT_W-1:0] sk_cos_reg;
    logic                       sk_last_reg;
    logic                       take;
    logic                       incoming;
    logic                       out_load;
    logic                       sk_load;

    always_comb
    begin
        take     = out_v_reg && !stall;
        // the pipeline only moves while the spare slot is free
        incoming = !sk_v_reg && res.vld;
        out_load = sk_v_reg ? take : (incoming && (!out_v_reg || take));
        sk_load  = incoming && out_v_reg && !take;

        if (out_load)
        begin
            out_v_next = 1'b1;
        end
        else if (take)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end

        sk_v_next = sk_v_reg ? !take : sk_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
            sk_v_reg  <= sk_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cos_reg  <= sk_v_reg ? sk_cos_reg : res.cosine;
            out_last_reg <= sk_v_reg ? sk_last_reg : res.last;
        end
        if (sk_load)
        begin
            sk_cos_reg  <= res.cosine;
            sk_last_reg <= res.last;
        end
    end

    assign adv    = !sk_v_reg;
    assign valid  = out_v_reg;
    assign cosine = out_cos_reg;
    assign last   = out_last_reg;

endmodule

`default_nettype wire

@@ design/cosine_taylor_range_reduced.sv @@
`default_nettype none

// Fixed-point cosine: takes an angle in radians (signed Q8.24) and returns its
// cosine as signed Q2.30, saturated to plus or minus one, with last_in copied
// to last_out. The magnitude is reduced modulo pi, keeping the parity of the
// quotient, folded by pi beyond pi/2 (negating the result) and fed to the
// degree-8 Taylor polynomial. One item is accepted every clock cycle while
// angle_stall is low. The item passes six range-reduction stages, fifteen
// polynomial stages (at most one multiplier each) and the output register, and
// it enters the first of these at the accepting edge. A two-entry output buffer
// lets the pipeline keep moving while a result waits; angle_stall rises only once
// both entries are full and is driven from a register.
module cosine_taylor_range_reduced
    import ctr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       angle_valid,
    output logic                       angle_stall,
    input  logic signed [ANGLE_W-1:0]  angle,
    input  logic                       last_in,
    output logic                       cosine_valid,
    input  logic                       cosine_stall,
    output logic signed [RESULT_W-1:0] cosine,
    output logic                       last_out
);

    logic     adv;
    ctr_red_t red;
    ctr_res_t res;

    ctr_reduce u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (angle_valid),
        .angle   (angle),
        .last_in (last_in),
        .red     (red)
    );

    ctr_poly u_poly (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .red   (red),
        .res   (res)
    );

    ctr_skid u_skid (
        .clk    (clk),
        .rst_n  (rst_n),
        .res    (res),
        .stall  (cosine_stall),
        .adv    (adv),
        .valid  (cosine_valid),
        .cosine (cosine),
        .last   (last_out)
    );

    assign angle_stall = !adv;

endmodule

`default_nettype wire

@@ design/ctr_checker.sv @@
`default_nettype none

module ctr_checker
    import ctr_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       angle_stall,
    input logic                       cosine_valid,
    input logic                       cosine_stall,
    input logic signed [RESULT_W-1:0] cosine,
    input logic                       last_out
);

    localparam logic signed [RESULT_W-1:0] COS_LIM = RESULT_W'(64'd1 << RESULT_FRAC_BITS);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cosine_valid && cosine_stall |=> cosine_valid && $stable(cosine) && $stable(last_out))
        else $error("stalled cosine item changed or dropped");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        cosine_valid |-> (cosine <= COS_LIM) && (cosine >= -COS_LIM))
        else $error("cosine beyond plus or minus one");

    a_stall_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !cosine_stall |=> !angle_stall)
        else $error("input stalled although the output was taken");

    a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> cosine_valid)
        else $error("input stalled with no result waiting");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(angle_stall) |-> $past(cosine_valid && cosine_stall))
        else $error("input stall rose without a stalled result");

endmodule

bind cosine_taylor_range_reduced ctr_checker u_checker (.*);

`default_nettype wire
